// ===== hw/rtl/obdrla_pkg.sv =====
package obdrla_pkg;

    localparam int unsigned PAYLOAD_DEPTH_DEF = 64;
    localparam int unsigned HEAD_LEN          = 6;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_4  = 8'h34;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_T  = 8'h54;

    localparam logic [1:0] VERDICT_NODATA  = 2'd0;
    localparam logic [1:0] VERDICT_VALUE   = 2'd1;
    localparam logic [1:0] VERDICT_IGNORED = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [1:0] verdict;
        logic       overflow;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic accept;
        logic classify;
        logic emit;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic done_hit;
        logic single;
        logic last_hit;
    } t_dp_status;

endpackage

// ===== hw/rtl/obdrla_ctrl.sv =====
module obdrla_ctrl
    import obdrla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.done_hit) begin
                        n_state = ST_CLASSIFY;
                    end
                end
            end
            ST_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                n_state = i_status.single ? ST_EMPTY : ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last_hit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/obdrla_datapath.sv =====
module obdrla_datapath
    import obdrla_pkg::*;
#(
    parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_result,
    output logic       o_strobe
);

    localparam int unsigned ADDR_W = $clog2(PAYLOAD_DEPTH);
    localparam int unsigned CNT_W  = $clog2(PAYLOAD_DEPTH + 1);

    logic [7:0]       r_mem [PAYLOAD_DEPTH];
    logic [7:0]       r_head [HEAD_LEN];
    logic [7:0]       r_rd_data;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;
    logic             r_dropped;
    logic             n_dropped;
    logic [7:0]       r_last_raw;
    logic [7:0]       n_last_raw;
    logic [1:0]       r_raw_seen;
    logic [1:0]       n_raw_seen;

    logic              keep;
    logic              full;
    logic              wr_mem;
    logic              finish;
    logic              is_nodata;
    logic              is_ignored;
    logic [1:0]        verdict;
    logic [ADDR_W-1:0] rd_addr;

    assign keep   = (i_item.data_byte != CH_CR) && (i_item.data_byte != CH_LF)
                 && (i_item.data_byte != CH_SP);
    assign full   = (r_count == CNT_W'(PAYLOAD_DEPTH));
    assign wr_mem = i_cmd.accept && keep && !full;
    assign finish = (i_cmd.emit && o_status.last_hit) || i_cmd.emit_empty;

    assign is_nodata  = (r_count >= CNT_W'(HEAD_LEN))
                     && (r_head[0] == CH_N) && (r_head[1] == CH_O)
                     && (r_head[2] == CH_D) && (r_head[3] == CH_A)
                     && (r_head[4] == CH_T) && (r_head[5] == CH_A);
    assign is_ignored = !is_nodata && (r_count >= CNT_W'(2))
                     && ((r_head[0] != CH_4) || (r_head[1] != CH_1));
    assign verdict    = is_nodata  ? VERDICT_NODATA :
                        is_ignored ? VERDICT_IGNORED : VERDICT_VALUE;

    assign o_status.done_hit = i_item.chunk_end
        && ((i_item.data_byte == CH_GT)
         || ((r_raw_seen != 2'd0) && (r_last_raw == CH_CR) && (i_item.data_byte == CH_LF)));
    assign o_status.single   = is_ignored || (r_count == '0);
    assign o_status.last_hit = (r_ptr == r_count);

    assign rd_addr = i_cmd.classify ? '0 : r_ptr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_mem) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_item.data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < HEAD_LEN; i++) begin
            if (wr_mem && (r_count == CNT_W'(i))) begin
                r_head[i] <= i_item.data_byte;
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_dropped  = r_dropped;
        n_last_raw = r_last_raw;
        n_raw_seen = r_raw_seen;
        if (i_cmd.accept) begin
            n_last_raw = i_item.data_byte;
            if (r_raw_seen != 2'd2) begin
                n_raw_seen = r_raw_seen + 2'd1;
            end
            if (keep) begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
        if (i_cmd.classify) begin
            n_ptr = CNT_W'(1);
        end
        if (i_cmd.emit) begin
            n_ptr = r_ptr + CNT_W'(1);
        end
        if (finish) begin
            n_count    = '0;
            n_dropped  = 1'b0;
            n_last_raw = 8'h00;
            n_raw_seen = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ptr      <= '0;
            r_dropped  <= 1'b0;
            r_last_raw <= 8'h00;
            r_raw_seen <= 2'd0;
        end else begin
            r_count    <= n_count;
            r_ptr      <= n_ptr;
            r_dropped  <= n_dropped;
            r_last_raw <= n_last_raw;
            r_raw_seen <= n_raw_seen;
        end
    end

    assign o_strobe              = i_cmd.emit || i_cmd.emit_empty;
    assign o_result.payload_byte = i_cmd.emit ? r_rd_data : 8'h00;
    assign o_result.byte_valid   = i_cmd.emit;
    assign o_result.verdict      = verdict;
    assign o_result.overflow     = r_dropped;
    assign o_result.last         = i_cmd.emit_empty || o_status.last_hit;

endmodule

// ===== hw/rtl/obd_response_line_assembler_core.sv =====
// Collects raw response bytes, one per cycle while busy is low, stripping CR, LF and
// space into a payload store of PAYLOAD_DEPTH bytes (extra bytes are dropped and
// flagged). A byte marked as chunk end that leaves the raw text ending in CR LF or
// '>' completes the response: busy rises for a classify step and then one emit step
// per result: one per stored byte for a value or no-data response, a single empty
// one when it is ignored or empty. The length of that burst is set by the single read
// port of the payload memory, which is walked one entry per cycle. Results appear
// on o_result for exactly one cycle with o_strobe high and cannot be held off; the
// final one carries last. No new byte is taken until the burst has ended.
module obd_response_line_assembler_core
    import obdrla_pkg::*;
#(
    parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_strobe
);

    t_dp_cmd    cmd;
    t_dp_status status;

    obdrla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    obdrla_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobed while idle");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.byte_valid) |-> o_result.last)
        else $error("empty result not final");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("result burst broken");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !busy)
        else $error("busy after final result");

endmodule
